// ----- src/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, widths and helpers for the spike de-sawtooth filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int SMP_W           = 16;
    localparam int VAL_W           = 24;
    localparam int THR_W           = 17;
    localparam int Q_W             = 18;
    localparam int DIFF_W          = VAL_W + 1;
    localparam int SERIES_LEN_DEF  = 64;
    localparam int MAX_PASSES_DEF  = 4095;
    localparam logic [THR_W-1:0] THR_RESET = 17'd58982;
    localparam logic [Q_W-1:0]   PROP_ONE  = 18'd65536;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [DIFF_W-1:0]       t_diff;

    typedef struct packed {
        logic  start;
        t_diff d2;
        t_diff md;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] q;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_SCAN_RD,
        S_SCAN_WT,
        S_DIV_ST,
        S_DIV_WT,
        S_DECIDE,
        S_WR,
        S_EMIT,
        S_EM_LD
    } t_state;

    function automatic t_diff abs_gap(t_val x, t_val y);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(x) - DIFF_W'(y);
        return d[DIFF_W-1] ? t_diff'(-d) : t_diff'(d);
    endfunction

endpackage

// ----- src/sdf_if.sv -----
// ----------------------------------------------------------------------------
// sdf_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface sdf_in_if import sdf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    is_good;
    logic                    last_in;

    modport source (output valid, sample, is_good, last_in, input ready);
    modport sink   (input valid, sample, is_good, last_in, output ready);
endinterface

interface sdf_out_if import sdf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] smoothed;
    logic                    last_out;

    modport source (output valid, smoothed, last_out, input ready);
    modport sink   (input valid, smoothed, last_out, output ready);
endinterface

// ----- src/spike_desawtooth_filter_unit.sv -----
// ----------------------------------------------------------------------------
// spike_desawtooth_filter_unit
// Collects a series, removes sawtooth spikes from its good samples, emits it.
// ----------------------------------------------------------------------------
// Words are taken one per cycle until the one marked last; no result appears
// before that. Smoothing then runs whole passes over the stored series: each
// pass reads every stored entry once from the series RAM (S_SCAN_RD, then
// S_SCAN_WT) and runs the serial divider for every interior good sample
// (but not when it sits level with both neighbours); every pass but the
// closing one ends with the correction write. Passes repeat until the
// largest correction proportion is at or below the configured threshold or
// the pass limit is reached. The series is then read out word by word, each
// word held until the sink has taken the one before; input is accepted
// again from the last word on.
module spike_desawtooth_filter_unit import sdf_pkg::*; #(
    parameter int SERIES_LEN = SERIES_LEN_DEF,
    parameter int MAX_PASSES = MAX_PASSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    sdf_in_if.sink           i_in_word,
    sdf_out_if.source        o_out_word
);
    localparam int AW = (SERIES_LEN > 1) ? $clog2(SERIES_LEN) : 1;
    localparam int CW = $clog2(SERIES_LEN + 1);
    localparam int PW = $clog2(MAX_PASSES + 1);
    localparam int MW = VAL_W + 1;
    localparam int GW = VAL_W + 2;
    localparam int XW = THR_W + 1 + GW;

    t_state r_state, n_state;

    logic [THR_W-1:0]     r_thr;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_ptr;
    logic [PW-1:0]        r_pass;
    logic [1:0]           r_ngood;
    t_val                 r_wa, r_wv, r_wb;
    logic [AW-1:0]        r_wvi, r_wbi;
    logic [THR_W-1:0]     r_best;
    logic [AW-1:0]        r_bi;
    t_val                 r_ba, r_bv, r_bb;
    logic signed [XW-1:0] r_prod;
    logic                 r_out_valid;
    t_val                 r_out_val;
    logic                 r_out_last;

    logic                 in_acc;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [MW-1:0]        ram_rdata;
    t_div_req             div_req;
    t_div_rsp             div_rsp;
    t_diff                d_ab, d_va, d_vb, md;
    logic signed [Q_W:0]  prop;
    logic signed [GW-1:0] gap2;
    logic signed [XW-1:0] rsum;
    logic signed [XW-1:0] nv;
    t_val                 nv_sat;
    logic                 stop;

    sdf_ram #(.DEPTH(SERIES_LEN), .WIDTH(MW), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc            = i_in_word.valid && i_in_word.ready;
    assign i_in_word.ready   = (r_state == S_LOAD);
    assign o_out_word.valid    = r_out_valid;
    assign o_out_word.smoothed = r_out_val;
    assign o_out_word.last_out = r_out_last;

    always_comb begin
        d_ab = abs_gap(r_wa, r_wb);
        d_va = abs_gap(r_wv, r_wa);
        d_vb = abs_gap(r_wv, r_wb);
        md   = (d_va > d_vb) ? d_va : d_vb;
        prop = $signed({1'b0, PROP_ONE}) - $signed({1'b0, div_rsp.q});
        gap2 = GW'(r_ba) + GW'(r_bb) - {r_bv[VAL_W-1], r_bv, 1'b0};
        rsum = r_prod + XW'(PROP_ONE);
        nv   = XW'(r_bv) + (rsum >>> 17);
        if (nv > XW'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (nv < XW'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
            nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            nv_sat = nv[VAL_W-1:0];
        end
        stop = (r_best == '0) || (r_best <= r_thr);
        div_req.start = (r_state == S_DIV_ST) && (md != '0);
        div_req.d2    = d_ab;
        div_req.md    = md;
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = {i_in_word.is_good, VAL_W'(i_in_word.sample) <<< 8};
        ram_raddr = r_ptr[AW-1:0];
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    ram_we = (r_cnt < CW'(SERIES_LEN));
                    if (i_in_word.last_in) begin
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                n_state = (r_pass == PW'(MAX_PASSES)) ? S_EMIT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = (r_ptr == r_cnt) ? S_DECIDE : S_SCAN_WT;
            end
            S_SCAN_WT: begin
                n_state = (ram_rdata[VAL_W] && r_ngood != 2'd0) ? S_DIV_ST : S_SCAN_RD;
                if (ram_rdata[VAL_W] && r_ngood == 2'd1) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV_ST: begin
                n_state = (md != '0) ? S_DIV_WT : S_SCAN_RD;
            end
            S_DIV_WT: begin
                if (div_rsp.done) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                n_state = stop ? S_EMIT : S_WR;
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_bi;
                ram_wdata = {1'b1, nv_sat};
                n_state   = S_PASS;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out_word.ready) begin
                    n_state = S_EM_LD;
                end
            end
            S_EM_LD: begin
                n_state = (r_ptr == r_cnt - CW'(1)) ? S_LOAD : S_EMIT;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_pass      <= '0;
            r_ngood     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_out_valid && o_out_word.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc && r_cnt < CW'(SERIES_LEN)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_PASS: begin
                    r_ptr   <= '0;
                    r_ngood <= '0;
                    r_best  <= '0;
                end
                S_SCAN_WT: begin
                    r_ptr <= r_ptr + CW'(1);
                    if (ram_rdata[VAL_W]) begin
                        r_wa  <= r_wv;
                        r_wv  <= r_wb;
                        r_wb  <= ram_rdata[VAL_W-1:0];
                        r_wvi <= r_wbi;
                        r_wbi <= r_ptr[AW-1:0];
                        if (r_ngood != 2'd3) begin
                            r_ngood <= r_ngood + 2'd1;
                        end
                    end
                end
                S_DIV_WT: begin
                    if (div_rsp.done && !prop[Q_W] && prop[THR_W-1:0] > r_best) begin
                        r_best <= prop[THR_W-1:0];
                        r_bi   <= r_wvi;
                        r_ba   <= r_wa;
                        r_bv   <= r_wv;
                        r_bb   <= r_wb;
                    end
                end
                S_DECIDE: begin
                    r_prod <= $signed({1'b0, r_best}) * gap2;
                    if (stop) begin
                        r_ptr <= '0;
                    end
                end
                S_WR: begin
                    r_pass <= r_pass + PW'(1);
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out_word.ready) begin
                        r_ptr <= r_ptr;
                    end
                end
                S_EM_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_val   <= ram_rdata[VAL_W-1:0];
                    r_out_last  <= (r_ptr == r_cnt - CW'(1));
                    if (r_ptr == r_cnt - CW'(1)) begin
                        r_cnt  <= '0;
                        r_pass <= '0;
                        r_ptr  <= '0;
                    end else begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

// ----- src/sdf_ram.sv -----
// ----------------------------------------------------------------------------
// sdf_ram
// Simple dual-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module sdf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 25,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- src/sdf_div.sv -----
// ----------------------------------------------------------------------------
// sdf_div
// Radix-2 restoring divider: q = floor(d2 * 2^16 / md), one bit per cycle.
// ----------------------------------------------------------------------------
module sdf_div import sdf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [DIFF_W:0]  r_rem;
    logic [DIFF_W:0]  r_dsr;
    logic [Q_W-1:0]   r_q;
    logic [4:0]       r_it;
    logic             r_busy;
    logic             r_done;
    logic [DIFF_W:0]  x;
    logic [DIFF_W:0]  dv;
    logic             ge;

    // first step tests 2*md, second md, then shift-and-subtract
    always_comb begin
        dv = (r_it == 5'd0) ? {r_dsr[DIFF_W-1:0], 1'b0} : r_dsr;
        x  = (r_it >= 5'd2) ? {r_rem[DIFF_W-1:0], 1'b0} : r_rem;
        ge = (x >= dv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
                r_rem  <= {1'b0, i_req.d2};
                r_dsr  <= {1'b0, i_req.md};
            end else if (r_busy) begin
                r_rem <= ge ? x - dv : x;
                r_q   <= {r_q[Q_W-2:0], ge};
                r_it  <= r_it + 5'd1;
                if (r_it == 5'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
endmodule

// ----- src/sdf_checker.sv -----
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks on the spike de-sawtooth filter, bound to the top level.
// ----------------------------------------------------------------------------
module sdf_checker import sdf_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VAL_W-1:0] i_out_data,
    input logic             i_out_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_out_last))
        else $error("result word changed while stalled");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input still open after final word");

    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> i_in_ready)
        else $error("input closed before final word");

    a_no_out_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result word appeared while loading");
endmodule

bind spike_desawtooth_filter_unit sdf_checker u_sdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_word.valid),
    .i_in_ready  (i_in_word.ready),
    .i_in_last   (i_in_word.last_in),
    .i_out_valid (o_out_word.valid),
    .i_out_ready (o_out_word.ready),
    .i_out_data  (o_out_word.smoothed),
    .i_out_last  (o_out_word.last_out)
);
